FILE: rtl/rpwc_pkg.sv
// Types and constants shared by the reverse proximity warning classifier modules.
package rpwc_pkg;

	localparam int unsigned RANGE_W    = 16;
	localparam int unsigned CNT_W      = 8;
	localparam int unsigned CFG_IDX_W  = 4;
	localparam int unsigned CFG_DATA_W = 16;

	localparam int unsigned IN_TDATA_W  = 32;
	localparam int unsigned IN_TUSER_W  = 4;
	localparam int unsigned OUT_TDATA_W = 24;
	localparam int unsigned OUT_TUSER_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_DANGER_THR  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WARNING_THR = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_EQUAL_MARGIN = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CONFIRM_CNT = 4'd3;

	localparam logic [RANGE_W-1:0] DANGER_THR_RST   = 16'd80;
	localparam logic [RANGE_W-1:0] WARNING_THR_RST  = 16'd128;
	localparam logic [RANGE_W-1:0] EQUAL_MARGIN_RST = 16'd16;
	localparam logic [CNT_W-1:0]   CONFIRM_CNT_RST  = 8'd2;

	localparam logic [CNT_W-1:0] CNT_MAX = 8'd255;

	typedef enum logic [1:0] {
		LVL_SAFE    = 2'd0,
		LVL_WARNING = 2'd1,
		LVL_DANGER  = 2'd2,
		LVL_ERROR   = 2'd3
	} level_t;

	typedef enum logic [1:0] {
		SIDE_NONE  = 2'd0,
		SIDE_LEFT  = 2'd1,
		SIDE_RIGHT = 2'd2,
		SIDE_BOTH  = 2'd3
	} side_t;

	typedef struct packed {
		logic               reversing;
		logic               fresh_sample;
		logic               left_ok;
		logic [RANGE_W-1:0] left_range;
		logic               right_ok;
		logic [RANGE_W-1:0] right_range;
	} item_t;

	typedef struct packed {
		side_t              near_side;
		logic [RANGE_W-1:0] nearest_range;
		logic               range_ok;
	} range_info_t;

	typedef struct packed {
		logic [RANGE_W-1:0] danger_threshold;
		logic [RANGE_W-1:0] warning_threshold;
		logic [RANGE_W-1:0] equal_margin;
		logic [CNT_W-1:0]   confirm_count;
	} cfg_t;

endpackage

FILE: rtl/rpwc_range_sel.sv
// Nearest-distance and side selection for the left and right sonars.
module rpwc_range_sel
	import rpwc_pkg::*;
(
	input  item_t              item,
	input  logic [RANGE_W-1:0] equal_margin,
	output range_info_t        info
);

	logic               left_le_right;
	logic [RANGE_W-1:0] diff;

	assign left_le_right = (item.left_range <= item.right_range);
	assign diff = left_le_right ? (item.right_range - item.left_range)
	                            : (item.left_range - item.right_range);

	always_comb begin
		info = '{near_side: SIDE_NONE, nearest_range: '0, range_ok: 1'b0};
		if (item.left_ok && item.right_ok) begin
			info.range_ok      = 1'b1;
			info.nearest_range = left_le_right ? item.left_range : item.right_range;
			if (diff <= equal_margin) begin
				info.near_side = SIDE_BOTH;
			end else if (item.left_range < item.right_range) begin
				info.near_side = SIDE_LEFT;
			end else begin
				info.near_side = SIDE_RIGHT;
			end
		end else if (item.left_ok) begin
			info.range_ok      = 1'b1;
			info.nearest_range = item.left_range;
			info.near_side     = SIDE_LEFT;
		end else if (item.right_ok) begin
			info.range_ok      = 1'b1;
			info.nearest_range = item.right_range;
			info.near_side     = SIDE_RIGHT;
		end
	end

endmodule

FILE: rtl/rpwc_level_ctrl.sv
// Level classification and debounce state that confirms a change of safety level.
module rpwc_level_ctrl
	import rpwc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        update,
	input  logic        reversing,
	input  logic        fresh_sample,
	input  range_info_t info,
	input  cfg_t        cfg,
	output level_t      level
);

	level_t           confirmed_q, confirmed_d;
	level_t           pending_q, pending_d;
	logic [CNT_W-1:0] count_q, count_d;
	level_t           want;
	logic [CNT_W-1:0] count_inc;

	always_comb begin
		if (!info.range_ok) begin
			want = LVL_ERROR;
		end else if (info.nearest_range <= cfg.danger_threshold) begin
			want = LVL_DANGER;
		end else if (info.nearest_range <= cfg.warning_threshold) begin
			want = LVL_WARNING;
		end else begin
			want = LVL_SAFE;
		end
	end

	// A new candidate level restarts the run at one; the run saturates at its maximum.
	assign count_inc = (pending_q != want) ? CNT_W'(1)
	                 : ((count_q != CNT_MAX) ? count_q + CNT_W'(1) : count_q);

	always_comb begin
		confirmed_d = confirmed_q;
		pending_d   = pending_q;
		count_d     = count_q;
		if (!reversing) begin
			confirmed_d = LVL_SAFE;
			pending_d   = LVL_SAFE;
			count_d     = '0;
		end else if (fresh_sample) begin
			pending_d = want;
			if (want == confirmed_q) begin
				count_d = '0;
			end else if (count_inc >= cfg.confirm_count) begin
				confirmed_d = want;
				count_d     = '0;
			end else begin
				count_d = count_inc;
			end
		end
	end

	always_comb begin
		level = confirmed_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			confirmed_q <= LVL_SAFE;
			pending_q   <= LVL_SAFE;
			count_q     <= '0;
		end else if (update) begin
			confirmed_q <= confirmed_d;
			pending_q   <= pending_d;
			count_q     <= count_d;
		end
	end

endmodule

FILE: rtl/reverse_proximity_warning_classifier_core.sv
// Top level of the reverse proximity warning classifier.
//
// Usage: sonar samples enter on the s_axis stream, one result per sample
// leaves on the m_axis stream. Configuration registers (danger threshold,
// warning threshold, equal margin, confirm count) are written through the
// cfg channel, which is always ready; write them only while no transaction
// is in flight.
// Each item is held in the input register, then in the result register,
// which drives m_axis_tvalid; while m_axis_tready is low, an item can wait
// in the input register.
// Throughput: one transaction per cycle while m_axis_tready is high. The
// input register, the compare-and-select logic and the level state update
// all complete in the cycle an item moves into the result register.
// Reset: arst_n clears both pipeline valids, the level state (safe, no
// pending run) and restores the register defaults.
// Stall: while m_axis_tready is low a result holds; one more item waits in
// the input register, and s_axis_tready drops only when both are full.
module reverse_proximity_warning_classifier_core
	import rpwc_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,

	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// [15:0] left_range, [31:16] right_range
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	// [0] reversing, [1] fresh_sample, [2] left_ok, [3] right_ok
	input  logic [IN_TUSER_W-1:0]  s_axis_tuser,

	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// [1:0] safety_level, [3:2] near_side, [19:4] nearest_range, [23:20] zero
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	// [0] range_ok
	output logic [OUT_TUSER_W-1:0] m_axis_tuser,

	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	cfg_t        cfg_q;
	item_t       item_s1;
	logic        valid_s1;
	logic        valid_s2;
	level_t      level_s2;
	range_info_t info_s2;
	logic        advance;
	range_info_t info;
	level_t      level;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.danger_threshold  <= DANGER_THR_RST;
			cfg_q.warning_threshold <= WARNING_THR_RST;
			cfg_q.equal_margin      <= EQUAL_MARGIN_RST;
			cfg_q.confirm_count     <= CONFIRM_CNT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_DANGER_THR:   cfg_q.danger_threshold  <= cfg_data;
				REG_WARNING_THR:  cfg_q.warning_threshold <= cfg_data;
				REG_EQUAL_MARGIN: cfg_q.equal_margin      <= cfg_data;
				REG_CONFIRM_CNT:  cfg_q.confirm_count     <= cfg_data[CNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (m_axis_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1.reversing    <= s_axis_tuser[0];
			item_s1.fresh_sample <= s_axis_tuser[1];
			item_s1.left_ok      <= s_axis_tuser[2];
			item_s1.right_ok     <= s_axis_tuser[3];
			item_s1.left_range   <= s_axis_tdata[RANGE_W-1:0];
			item_s1.right_range  <= s_axis_tdata[2*RANGE_W-1:RANGE_W];
		end
	end

	rpwc_range_sel u_range_sel (
		.item         (item_s1),
		.equal_margin (cfg_q.equal_margin),
		.info         (info)
	);

	rpwc_level_ctrl u_level_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.update       (advance),
		.reversing    (item_s1.reversing),
		.fresh_sample (item_s1.fresh_sample),
		.info         (info),
		.cfg          (cfg_q),
		.level        (level)
	);

	// When not reversing the whole result reads as safe with no distance.
	always_ff @(posedge clk) begin
		if (advance) begin
			level_s2 <= level;
			if (item_s1.reversing) begin
				info_s2 <= info;
			end else begin
				info_s2 <= '{near_side: SIDE_NONE, nearest_range: '0, range_ok: 1'b0};
			end
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {4'b0000, info_s2.nearest_range, info_s2.near_side, level_s2};
	assign m_axis_tuser  = info_s2.range_ok;

endmodule

FILE: rtl/rpwc_checker.sv
// Port-level assertions for the classifier core and the bind that attaches them.
module rpwc_checker
	import rpwc_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_axis_tready,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input logic [OUT_TUSER_W-1:0] m_axis_tuser,
	input logic                   cfg_valid,
	input logic                   cfg_ready
);

	// A result that is not taken stays on the bus.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result transaction dropped while stalled");

	// The input side stalls only when a finished result is being held back.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled without output back-pressure");

	// With no valid sonar there is neither a side nor a distance.
	a_no_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[19:2] == 18'd0)
		else $error("side or distance reported without a valid sonar");

	// A valid distance always comes with a side.
	a_range_side: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[3:2] != SIDE_NONE)
		else $error("valid distance reported with no side");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write refused");

endmodule

bind reverse_proximity_warning_classifier_core rpwc_checker u_rpwc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.cfg_valid     (cfg_valid),
	.cfg_ready     (cfg_ready)
);
